### sv/mrse_pkg.sv
// Shared types, constants and helper functions for the modular RPN stack evaluator.
// It has no dependencies. mrse_modmul and modular_rpn_stack_evaluator_top import it.
package mrse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int VAL_W       = 30;
    localparam int LIT_W       = 38;
    localparam int FUNC_W      = 2;
    localparam int STAT_W      = 2;
    localparam int STEP_W      = $clog2(VAL_W + 1);
    localparam int FOLD_W      = 34;

    localparam logic [VAL_W-1:0] PRIME_MOD = 30'd1000000007;
    // The weight of bit 30 reduced modulo the prime, used to fold literal bits above bit 29.
    localparam logic [VAL_W-1:0] WRAP_MOD  = 30'd73741817;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH = 2'd0,
        FN_ADD  = 2'd1,
        FN_SUB  = 2'd2,
        FN_MUL  = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // Brings a value below twice the modulus into the range of residues.
    function automatic logic [VAL_W-1:0] mod_fold(input logic [VAL_W:0] x);
        logic [VAL_W:0] d;
        d = x - {1'b0, PRIME_MOD};
        if (x >= {1'b0, PRIME_MOD})
        begin
            return d[VAL_W-1:0];
        end
        return x[VAL_W-1:0];
    endfunction

endpackage

### sv/mrse_modmul.sv
// Bit-serial modular multiplier: one bit of the first operand per cycle, MSB first.
// It uses mrse_pkg.
module mrse_modmul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mrse_pkg::VAL_W-1:0]  a_in,
    input  logic [mrse_pkg::VAL_W-1:0]  b_in,
    output logic                        done,
    output logic [mrse_pkg::VAL_W-1:0]  result
);
    import mrse_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [VAL_W-1:0]  acc_reg;
    logic [VAL_W-1:0]  a_reg;
    logic [VAL_W-1:0]  b_reg;

    logic [VAL_W-1:0]  dbl_red;
    logic [VAL_W:0]    sum;
    logic [VAL_W-1:0]  acc_step;

    always_comb
    begin
        dbl_red  = mod_fold({acc_reg, 1'b0});
        sum      = {1'b0, dbl_red} + (a_reg[VAL_W-1] ? {1'b0, b_reg} : {(VAL_W + 1){1'b0}});
        acc_step = mod_fold(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= STEP_W'(VAL_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a_in;
            b_reg   <= b_in;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_step;
            a_reg   <= {a_reg[VAL_W-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

    // The accumulator stays a proper residue while the unit steps.
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> acc_reg < PRIME_MOD)
        else $error("modmul accumulator out of range");

    // A new operation never starts on top of one in progress.
    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("modmul started while busy");

    // A completion always follows a cycle of work.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(done_reg) |-> $past(busy_reg))
        else $error("modmul done without work");

endmodule

### sv/modular_rpn_stack_evaluator_top.sv
// Reverse Polish evaluator modulo 1000000007 with a 64-entry stack held in a synchronous RAM.
// One input transaction at a time: an add or subtract passes through S_READ and then S_DONE;
// a push passes through S_FOLD and S_REDUCE, which fold the literal into a residue, then S_DONE;
// a multiply passes through S_READ and waits in S_BUSY for the bit-serial modular multiplier,
// which steps one operand bit per cycle over 30 bits. An underflow or overflow goes straight to
// S_DONE and leaves the stack unchanged. The result register lets a finished result wait while
// the next transaction is accepted. Uses mrse_pkg and mrse_modmul.
module modular_rpn_stack_evaluator_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mrse_pkg::FUNC_W-1:0]  func,
    input  logic signed [mrse_pkg::LIT_W-1:0] literal,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mrse_pkg::VAL_W-1:0]   top_value,
    output logic [mrse_pkg::VAL_W-1:0]   bottom_value,
    output logic [mrse_pkg::PTR_W-1:0]   depth,
    output logic [mrse_pkg::STAT_W-1:0]  status
);
    import mrse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FOLD,
        S_REDUCE,
        S_BUSY,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    sp_reg, sp_next;
    logic [VAL_W-1:0]    top_reg, top_next;
    logic [VAL_W-1:0]    bottom_reg, bottom_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic                neg_reg, neg_next;
    logic [LIT_W-1:0]    mag_reg, mag_next;
    logic [FOLD_W-1:0]   fold_reg, fold_next;
    logic [VAL_W-1:0]    result_reg, result_next;
    status_t             stat_reg, stat_next;
    logic                out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]    out_top_reg, out_top_next;
    logic [VAL_W-1:0]    out_bottom_reg, out_bottom_next;
    logic [PTR_W-1:0]    out_depth_reg, out_depth_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;

    logic [VAL_W-1:0]    stack_mem [STACK_DEPTH];
    logic [VAL_W-1:0]    rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ADDR_W-1:0]   mem_raddr;

    logic [PTR_W-1:0]    sp_minus1;
    logic [PTR_W-1:0]    sp_minus2;
    logic [LIT_W-1:0]    lit_bits;
    logic [LIT_W-1:0]    lit_mag;
    logic [FOLD_W-1:0]   fold_wide;
    logic [VAL_W:0]      fold_narrow;
    logic [VAL_W-1:0]    red_val;
    logic                mm_start;
    logic [VAL_W-1:0]    mm_a;
    logic [VAL_W-1:0]    mm_b;
    logic                mm_done;
    logic [VAL_W-1:0]    mm_result;

    mrse_modmul u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .a_in   (mm_a),
        .b_in   (mm_b),
        .done   (mm_done),
        .result (mm_result)
    );

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        sp_minus1   = sp_reg - PTR_W'(1);
        sp_minus2   = sp_reg - PTR_W'(2);
        lit_bits    = literal;
        lit_mag     = lit_bits[LIT_W-1] ? (LIT_W'(0) - lit_bits) : lit_bits;
        fold_wide   = FOLD_W'(mag_reg[LIT_W-1:VAL_W]) * FOLD_W'(WRAP_MOD)
                      + FOLD_W'(mag_reg[VAL_W-1:0]);
        fold_narrow = (VAL_W + 1)'(fold_reg[FOLD_W-1:VAL_W]) * (VAL_W + 1)'(WRAP_MOD)
                      + {1'b0, fold_reg[VAL_W-1:0]};
        red_val     = mod_fold(fold_narrow);

        state_next      = state_reg;
        sp_next         = sp_reg;
        top_next        = top_reg;
        bottom_next     = bottom_reg;
        func_next       = func_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        fold_next       = fold_reg;
        result_next     = result_reg;
        stat_next       = stat_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_top_next    = out_top_reg;
        out_bottom_next = out_bottom_reg;
        out_depth_next  = out_depth_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = sp_reg[ADDR_W-1:0];
        mem_raddr       = sp_minus2[ADDR_W-1:0];
        mm_start        = 1'b0;
        mm_a            = top_reg;
        mm_b            = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    neg_next  = lit_bits[LIT_W-1];
                    if (func == FN_PUSH)
                    begin
                        if (sp_reg >= PTR_W'(STACK_DEPTH))
                        begin
                            stat_next  = ST_OVERFLOW;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            stat_next  = ST_OK;
                            mag_next   = lit_mag;
                            state_next = S_FOLD;
                        end
                    end
                    else if (sp_reg < PTR_W'(2))
                    begin
                        stat_next  = ST_UNDERFLOW;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        stat_next  = ST_OK;
                        mem_re     = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                case (func_reg)
                    FN_ADD:
                    begin
                        result_next = mod_fold({1'b0, top_reg} + {1'b0, rd_data_reg});
                        state_next  = S_DONE;
                    end
                    FN_SUB:
                    begin
                        result_next = mod_fold({1'b0, rd_data_reg} + {1'b0, PRIME_MOD}
                                               - {1'b0, top_reg});
                        state_next  = S_DONE;
                    end
                    default:
                    begin
                        mm_start   = 1'b1;
                        state_next = S_BUSY;
                    end
                endcase
            end
            S_FOLD:
            begin
                fold_next  = fold_wide;
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                if (neg_reg && red_val != '0)
                begin
                    result_next = PRIME_MOD - red_val;
                end
                else
                begin
                    result_next = red_val;
                end
                state_next = S_DONE;
            end
            S_BUSY:
            begin
                if (mm_done)
                begin
                    result_next = mm_result;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (stat_reg == ST_OK)
                    begin
                        mem_we   = 1'b1;
                        top_next = result_reg;
                        if (func_reg == FN_PUSH)
                        begin
                            mem_waddr = sp_reg[ADDR_W-1:0];
                            sp_next   = sp_reg + PTR_W'(1);
                            if (sp_reg == '0)
                            begin
                                bottom_next = result_reg;
                            end
                        end
                        else
                        begin
                            mem_waddr = sp_minus2[ADDR_W-1:0];
                            sp_next   = sp_minus1;
                            if (sp_reg == PTR_W'(2))
                            begin
                                bottom_next = result_reg;
                            end
                        end
                    end
                    out_valid_next  = 1'b1;
                    out_top_next    = (sp_next == '0) ? '0 : top_next;
                    out_bottom_next = (sp_next == '0) ? '0 : bottom_next;
                    out_depth_next  = sp_next;
                    out_status_next = stat_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sp_reg         <= '0;
            top_reg        <= '0;
            bottom_reg     <= '0;
            func_reg       <= '0;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
            fold_reg       <= '0;
            result_reg     <= '0;
            stat_reg       <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_top_reg    <= '0;
            out_bottom_reg <= '0;
            out_depth_reg  <= '0;
            out_status_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            top_reg        <= top_next;
            bottom_reg     <= bottom_next;
            func_reg       <= func_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            fold_reg       <= fold_next;
            result_reg     <= result_next;
            stat_reg       <= stat_next;
            out_valid_reg  <= out_valid_next;
            out_top_reg    <= out_top_next;
            out_bottom_reg <= out_bottom_next;
            out_depth_reg  <= out_depth_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= result_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign top_value    = out_top_reg;
    assign bottom_value = out_bottom_reg;
    assign depth        = out_depth_reg;
    assign status       = out_status_reg;

    // The stack pointer never runs past the stack.
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= PTR_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    // A successful transaction always leaves at least one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == ST_OK |-> out_depth_reg != '0)
        else $error("successful result with an empty stack");

    // The cached top and bottom entries are proper residues.
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg != '0 |-> top_reg < PRIME_MOD && bottom_reg < PRIME_MOD)
        else $error("cached stack entry out of range");

    // The multiplier only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n) mm_done |-> state_reg == S_BUSY)
        else $error("multiplier finished outside the busy state");

endmodule

### test/tb_modular_rpn_stack_evaluator_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for modular_rpn_stack_evaluator_top: it keeps its own copy of the stack.
// Directed, then random transactions; most random ones run with idling on both sides. Depends on mrse_pkg.
module tb_modular_rpn_stack_evaluator_top;

    import mrse_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 1950;

    typedef struct {
        logic [VAL_W-1:0] top;
        logic [VAL_W-1:0] bottom;
        logic [PTR_W-1:0] level;
        status_t          stat;
    } rpn_result_t;

    class rpn_stack_mirror;
        localparam longint unsigned MODULUS = 64'd1000000007;

        logic [VAL_W-1:0] entries[STACK_DEPTH];
        int unsigned      level;
        rpn_result_t      pending[$];
        int unsigned      failures;

        function new();
            level = 0;
            failures = 0;
        endfunction

        function logic [VAL_W-1:0] residue_of(logic signed [LIT_W-1:0] lit);
            longint v;
            longint r;
            v = lit;
            r = v % longint'(MODULUS);
            if (r < 0)
            begin
                r = r + longint'(MODULUS);
            end
            return r[VAL_W-1:0];
        endfunction

        function void note_transaction(func_t op, logic signed [LIT_W-1:0] lit);
            status_t         st;
            longint unsigned a;
            longint unsigned b;
            longint unsigned r;
            rpn_result_t     res;
            st = ST_OK;
            if (op == FN_PUSH)
            begin
                if (level >= STACK_DEPTH)
                begin
                    st = ST_OVERFLOW;
                end
                else
                begin
                    entries[level] = residue_of(lit);
                    level++;
                end
            end
            else if (level < 2)
            begin
                st = ST_UNDERFLOW;
            end
            else
            begin
                a = 64'(entries[level-1]);
                b = 64'(entries[level-2]);
                case (op)
                    FN_ADD:  r = (a + b) % MODULUS;
                    FN_SUB:  r = (b + MODULUS - a) % MODULUS;
                    default: r = (a * b) % MODULUS;
                endcase
                level--;
                entries[level-1] = r[VAL_W-1:0];
            end
            res.top    = (level == 0) ? '0 : entries[level-1];
            res.bottom = (level == 0) ? '0 : entries[0];
            res.level  = level[PTR_W-1:0];
            res.stat   = st;
            pending.push_back(res);
        endfunction

        function void check_result(logic [VAL_W-1:0] top, logic [VAL_W-1:0] bottom,
                                   logic [PTR_W-1:0] lvl, logic [STAT_W-1:0] stat);
            rpn_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: result with no transaction waiting, top %0d depth %0d",
                         $time, top, lvl);
                failures++;
                return;
            end
            e = pending.pop_front();
            if (top !== e.top)
            begin
                $display("%0t: top_value expected %0d actual %0d", $time, e.top, top);
                failures++;
            end
            if (bottom !== e.bottom)
            begin
                $display("%0t: bottom_value expected %0d actual %0d", $time, e.bottom, bottom);
                failures++;
            end
            if (lvl !== e.level)
            begin
                $display("%0t: depth expected %0d actual %0d", $time, e.level, lvl);
                failures++;
            end
            if (stat !== e.stat)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.stat, stat);
                failures++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [FUNC_W-1:0]       func = '0;
    logic signed [LIT_W-1:0] literal = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [VAL_W-1:0]        top_value;
    logic [VAL_W-1:0]        bottom_value;
    logic [PTR_W-1:0]        depth;
    logic [STAT_W-1:0]       status;

    int unsigned     send_idle = 0;
    int unsigned     recv_idle = 0;
    int unsigned     cycle_count = 0;
    int              sent = 0;
    rpn_stack_mirror mirror;

    modular_rpn_stack_evaluator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .literal      (literal),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .top_value    (top_value),
        .bottom_value (bottom_value),
        .depth        (depth),
        .status       (status)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_modular_rpn_stack_evaluator_top failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            mirror.check_result(top_value, bottom_value, depth, status);
        end
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    task send_item(func_t op, logic signed [LIT_W-1:0] lit);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        literal  <= lit;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        mirror.note_transaction(op, lit);
        sent++;
    endtask

    task wait_for_results();
        in_valid <= 1'b0;
        while (mirror.pending.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function logic signed [LIT_W-1:0] pick_literal();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return LIT_W'($urandom_range(20));
            1: return -$signed({1'b0, 37'($urandom_range(20))});
            2: return 38'sd1000000007 + $signed(38'($urandom_range(6))) - 38'sd3;
            3: return -38'sd1000000007 + $signed(38'($urandom_range(6))) - 38'sd3;
            4: return {1'b0, {(LIT_W-1){1'b1}}};
            5: return {1'b1, {(LIT_W-1){1'b0}}};
            default: return raw[LIT_W-1:0];
        endcase
    endfunction

    function func_t pick_operator();
        return func_t'($urandom_range(1, 3));
    endfunction

    task run_random(int count);
        int target;
        int mode;
        int seg;
        target = sent + count;
        while (sent < target)
        begin
            mode = $urandom_range(99);
            if (mode < 12)
            begin
                while (mirror.level < STACK_DEPTH)
                begin
                    send_item(FN_PUSH, pick_literal());
                end
                repeat ($urandom_range(1, 3)) send_item(FN_PUSH, pick_literal());
            end
            else if (mode < 20)
            begin
                while (mirror.level >= 2)
                begin
                    send_item(pick_operator(), pick_literal());
                end
                repeat ($urandom_range(1, 2)) send_item(pick_operator(), pick_literal());
            end
            else if (mode < 32)
            begin
                repeat ($urandom_range(3, 12)) send_item(func_t'($urandom_range(3)), pick_literal());
            end
            else
            begin
                seg = $urandom_range(5, 40);
                repeat (seg)
                begin
                    if (mirror.level < 2)
                    begin
                        send_item(FN_PUSH, pick_literal());
                    end
                    else if (mirror.level >= STACK_DEPTH - 4 || $urandom_range(1))
                    begin
                        send_item(pick_operator(), pick_literal());
                    end
                    else
                    begin
                        send_item(FN_PUSH, pick_literal());
                    end
                end
            end
        end
    endtask

    initial
    begin
        mirror = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(FN_ADD, 38'sd0);
        send_item(FN_SUB, 38'sd0);
        send_item(FN_MUL, 38'sd0);
        send_item(FN_PUSH, 38'sd0);
        send_item(FN_ADD, 38'sd0);
        send_item(FN_PUSH, {1'b0, {(LIT_W-1){1'b1}}});
        send_item(FN_PUSH, {1'b1, {(LIT_W-1){1'b0}}});
        send_item(FN_ADD, 38'sd0);
        send_item(FN_PUSH, 38'sd99999999999);
        send_item(FN_SUB, 38'sd0);
        send_item(FN_PUSH, -38'sd9999999999);
        send_item(FN_MUL, {LIT_W{1'b1}});
        send_item(FN_PUSH, 38'sd1000000006);
        send_item(FN_PUSH, 38'sd1000000006);
        send_item(FN_MUL, 38'sd0);
        send_item(FN_PUSH, 38'sd0);
        send_item(FN_PUSH, 38'sd5);
        send_item(FN_SUB, 38'sd0);
        send_item(FN_PUSH, 38'sd1000000007);
        send_item(FN_PUSH, -38'sd1000000007);
        send_item(FN_ADD, 38'sd0);
        send_item(FN_PUSH, -38'sd1);
        send_item(FN_MUL, 38'sd0);
        wait_for_results();

        send_idle = 22;
        recv_idle = 79;
        run_random(RANDOM_ITEMS / 3);
        send_idle = 79;
        recv_idle = 22;
        run_random(RANDOM_ITEMS / 6);
        wait_for_results();
        run_random(RANDOM_ITEMS / 6);
        send_idle = 0;
        recv_idle = 0;
        run_random(RANDOM_ITEMS / 3);

        wait_for_results();
        repeat (60) @(posedge clk);
        if (mirror.failures == 0)
        begin
            $display("tb_modular_rpn_stack_evaluator_top passed");
        end
        else
        begin
            $display("tb_modular_rpn_stack_evaluator_top failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/mrse_pkg.sv
sv/mrse_modmul.sv
sv/modular_rpn_stack_evaluator_top.sv
test/tb_modular_rpn_stack_evaluator_top.sv
